[rtl/core/wat_pkg.sv]
// ----------------------------------------------------------------------------
// wat_pkg
// Shared widths, action codes and defaults for the windowed average block.
// ----------------------------------------------------------------------------
package wat_pkg;

  localparam int MAX_WINDOW_DEF = 16;

  localparam int RAW_W      = 24;
  localparam int SAMPLE_W   = 20;
  localparam int SUM_W      = 24;
  localparam int TARED_W    = 21;
  localparam int CNT_OUT_W  = 5;
  localparam int WLEN_W     = 5;

  // converter word sits in the top of 32 bits, then divided by 4096
  localparam int CONV_SHIFT = 12 - (32 - RAW_W);

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic REG_WINDOW_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    ACT_CONVERT   = 2'd0,
    ACT_TARE      = 2'd1,
    ACT_CALIBRATE = 2'd2,
    ACT_CLEAR     = 2'd3
  } action_t;

endpackage

[rtl/core/windowed_average_with_tare.sv]
// ----------------------------------------------------------------------------
// windowed_average_with_tare
// Moving average over converter samples with tare offset and calibration.
// ----------------------------------------------------------------------------
// Each transaction runs through these steps from acceptance to the result
// register: one to update the sample window, one to start the divider, 24
// steps of the serial divider that forms the window average, one to collect
// the quotient and one to load the result, which waits while the output
// register still holds an unaccepted result. A new transaction is taken
// from the cycle after the result is loaded, so only one is in progress at
// a time, while that result may still wait in the output register.
module windowed_average_with_tare import wat_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready,
  // input channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_action,
  input  logic [RAW_W-1:0]          in_raw_word,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [TARED_W-1:0] out_tared_average,
  output logic signed [SAMPLE_W-1:0] out_raw_average,
  output logic signed [TARED_W-1:0] out_latest_tared,
  output logic signed [SAMPLE_W-1:0] out_latest_raw,
  output logic [CNT_OUT_W-1:0]      out_count_held,
  output logic                      out_window_full,
  output logic                      out_average_valid,
  output logic                      out_calibration_fired
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int EXT_W = CNT_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_START,
    S_DIVIDE,
    S_FINISH
  } state_t;

  state_t                     state_r;
  logic [WLEN_W-1:0]          wlen_r;
  logic signed [SAMPLE_W-1:0] tare_r;
  logic signed [SAMPLE_W-1:0] latest_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]           count_r;
  logic [PTR_W-1:0]           newest_r;
  logic [PTR_W-1:0]           oldest_r;
  logic                       pending_r;
  logic                       fired_r;
  action_t                    action_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] avg_r;

  logic                       out_valid_r;
  logic signed [TARED_W-1:0]  out_tared_average_r;
  logic signed [SAMPLE_W-1:0] out_raw_average_r;
  logic signed [TARED_W-1:0]  out_latest_tared_r;
  logic signed [SAMPLE_W-1:0] out_latest_raw_r;
  logic [CNT_OUT_W-1:0]       out_count_held_r;
  logic                       out_window_full_r;
  logic                       out_average_valid_r;
  logic                       out_calibration_fired_r;

  logic [CNT_W-1:0]           eff_len;
  logic signed [RAW_W-1:0]    word;
  logic signed [RAW_W-1:0]    biased;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [EXT_W-1:0]           count_inc;
  logic                       overflow;
  logic [EXT_W-1:0]           newest_inc;
  logic [EXT_W-1:0]           oldest_inc;
  logic [PTR_W-1:0]           newest_wrap;
  logic [PTR_W-1:0]           oldest_wrap;
  logic [PTR_W-1:0]           clear_ptr;
  logic signed [SUM_W-1:0]    sum_base;
  logic signed [SUM_W-1:0]    sum_add;
  logic signed [SAMPLE_W-1:0] tare_nxt;
  logic                       cfg_write;

  logic                       ram_we;
  logic [PTR_W-1:0]           ram_waddr;
  logic [SAMPLE_W-1:0]        ram_wdata;
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic signed [SAMPLE_W-1:0] ram_rdata_s;

  logic                       div_start;
  logic                       div_done;
  logic signed [SUM_W-1:0]    div_quot;

  // effective window length, clamped to 1..MAX_WINDOW
  always_comb begin
    if (wlen_r == '0) begin
      eff_len = CNT_W'(1);
    end else if (32'(wlen_r) > 32'(MAX_WINDOW)) begin
      eff_len = CNT_W'(MAX_WINDOW);
    end else begin
      eff_len = CNT_W'(wlen_r);
    end
  end

  // sample = word / 16, truncated toward zero
  assign word      = signed'(in_raw_word);
  assign biased    = word + (word[RAW_W-1] ? RAW_W'((1 << CONV_SHIFT) - 1) : RAW_W'(0));
  assign sample_in = biased[RAW_W-1:CONV_SHIFT];

  assign count_inc   = EXT_W'(count_r) + 1'b1;
  assign overflow    = count_inc > EXT_W'(eff_len);
  assign newest_inc  = EXT_W'(newest_r) + 1'b1;
  assign oldest_inc  = EXT_W'(oldest_r) + 1'b1;
  assign newest_wrap = (newest_inc >= EXT_W'(eff_len)) ? '0 : newest_inc[PTR_W-1:0];
  assign oldest_wrap = (oldest_inc >= EXT_W'(eff_len)) ? '0 : oldest_inc[PTR_W-1:0];
  assign clear_ptr   = PTR_W'(eff_len - 1'b1);

  assign ram_rdata_s = signed'(ram_rdata);
  assign sum_base    = overflow ? sum_r - SUM_W'(ram_rdata_s) : sum_r;
  assign sum_add     = sum_base + SUM_W'(sample_r);

  assign ram_we    = (state_r == S_UPDATE) &&
                     ((action_r == ACT_CONVERT && !pending_r) || action_r == ACT_CLEAR);
  assign ram_waddr = (action_r == ACT_CLEAR) ? clear_ptr : newest_wrap;
  assign ram_wdata = (action_r == ACT_CLEAR) ? '0 : sample_r;

  assign div_start = (state_r == S_START);
  assign tare_nxt  = (action_r == ACT_TARE) ? avg_r : tare_r;

  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LENGTH);
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_WINDOW_LENGTH) ? APB_DW'(wlen_r) : '0;

  assign in_ready  = (state_r == S_IDLE);

  wat_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (oldest_r),
    .rdata (ram_rdata)
  );

  wat_div #(
    .DIV_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wlen_r      <= WLEN_W'(1);
      tare_r      <= '0;
      latest_r    <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      newest_r    <= '0;
      oldest_r    <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write) begin
        wlen_r <= pwdata[WLEN_W-1:0];
      end
      if (out_valid_r && out_ready && state_r != S_FINISH) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            action_r <= action_t'(in_action);
            sample_r <= sample_in;
            fired_r  <= 1'b0;
            state_r  <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          unique case (action_r)
            ACT_CONVERT: begin
              if (pending_r) begin
                pending_r <= 1'b0;
                fired_r   <= 1'b1;
              end else begin
                count_r  <= overflow ? eff_len : count_inc[CNT_W-1:0];
                if (overflow) begin
                  oldest_r <= oldest_wrap;
                end
                newest_r <= newest_wrap;
                sum_r    <= sum_add;
                latest_r <= sample_r;
              end
            end
            ACT_TARE: begin
            end
            ACT_CALIBRATE: begin
              pending_r <= 1'b1;
            end
            ACT_CLEAR: begin
              count_r  <= '0;
              sum_r    <= '0;
              oldest_r <= '0;
              newest_r <= clear_ptr;
              latest_r <= '0;
            end
            default: begin
            end
          endcase
          state_r <= S_START;
        end
        S_START: begin
          state_r <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (div_done) begin
            avg_r   <= (count_r == '0) ? '0 : div_quot[SAMPLE_W-1:0];
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid_r || out_ready) begin
            tare_r                  <= tare_nxt;
            out_valid_r             <= 1'b1;
            out_tared_average_r     <= TARED_W'(avg_r) - TARED_W'(tare_nxt);
            out_raw_average_r       <= avg_r;
            out_latest_tared_r      <= TARED_W'(latest_r) - TARED_W'(tare_nxt);
            out_latest_raw_r        <= latest_r;
            out_count_held_r        <= CNT_OUT_W'(count_r);
            out_window_full_r       <= count_r >= eff_len;
            out_average_valid_r     <= count_r != '0;
            out_calibration_fired_r <= fired_r;
            state_r                 <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_tared_average     = out_tared_average_r;
  assign out_raw_average       = out_raw_average_r;
  assign out_latest_tared      = out_latest_tared_r;
  assign out_latest_raw        = out_latest_raw_r;
  assign out_count_held        = out_count_held_r;
  assign out_window_full       = out_window_full_r;
  assign out_average_valid     = out_average_valid_r;
  assign out_calibration_fired = out_calibration_fired_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_WINDOW))
    else $error("sample count above window capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("transaction accepted while another is in progress");

  a_div_done_window: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIVIDE)
    else $error("divider finished outside the divide phase");

  a_fired_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FINISH && fired_r |-> !pending_r)
    else $error("calibration still armed after swallowing a conversion");

endmodule

[rtl/core/wat_ram.sv]
// ----------------------------------------------------------------------------
// wat_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module wat_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/wat_div.sv]
// ----------------------------------------------------------------------------
// wat_div
// Serial restoring divider: signed sum by unsigned count, one quotient bit
// per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module wat_div import wat_pkg::*; #(
  parameter int DIV_W = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [DIV_W-1:0]        divisor,
  output logic                    done,
  output logic signed [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  mag_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  dvs_r;
  logic              neg_r;

  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              fits;

  assign trial = {rem_r, mag_r[SUM_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(SUM_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      neg_r <= dividend[SUM_W-1];
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      mag_r <= {mag_r[SUM_W-2:0], fits};
      rem_r <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -signed'(mag_r) : signed'(mag_r);

endmodule
